// ===== hw/rtl/sl3_pkg.sv =====
// ----------------------------------------------------------------------------
// sl3_pkg
// Types and constants shared by the 3x3 solver pipeline.
// ----------------------------------------------------------------------------
package sl3_pkg;

    localparam int FW        = 32;        // Q16.16 entry width
    localparam int DW        = 98;        // signed exact determinant width
    localparam int UW        = DW - 1;    // magnitude of a determinant
    localparam int DVW       = UW + 1;    // divisor width (2 * |det|)
    localparam int NW        = UW + 18;   // dividend width
    localparam int SW        = 66;        // sum of squares
    localparam int TW        = 48;        // tolerance register
    localparam int RHW       = 114;       // tolerance times sum of squares
    localparam int QW        = 32;        // quotient bits
    localparam int DIV_STEPS = QW;
    localparam int LANES     = 3;
    localparam int RSH_W     = DW + 1 - 32;   // rounded determinant before clamp

    localparam logic [TW-1:0] TOL_RESET = TW'(281);

    typedef logic signed [FW-1:0] fix_t;
    typedef fix_t [8:0] sl3_mat_t;       // index row * 3 + col

    typedef enum logic [1:0] {
        ST_SOLVED    = 2'd0,
        ST_SINGULAR  = 2'd1,
        ST_SATURATED = 2'd2
    } sl3_status_t;

    typedef struct packed {
        fix_t m00;
        fix_t m01;
        fix_t m02;
        fix_t m10;
        fix_t m11;
        fix_t m12;
        fix_t m20;
        fix_t m21;
        fix_t m22;
        fix_t rhs0;
        fix_t rhs1;
        fix_t rhs2;
    } sl3_in_t;

    typedef struct packed {
        fix_t               sol0;
        fix_t               sol1;
        fix_t               sol2;
        logic signed [63:0] determinant;
        sl3_status_t        status;
    } sl3_out_t;

    typedef struct packed {
        logic [LANES-1:0][DVW-1:0] rem;
        logic [LANES-1:0][QW-1:0]  nlow;
        logic [LANES-1:0][QW-1:0]  q;
        logic [LANES-1:0]          ovf;
        logic [LANES-1:0]          neg;
        logic [DVW-1:0]            dvs;
        logic                      singular;
        logic                      det_sat;
        logic signed [63:0]        det;
    } sl3_div_t;

endpackage

// ===== hw/rtl/sl3_det3.sv =====
// ----------------------------------------------------------------------------
// sl3_det3
// Exact 3x3 determinant by cofactor expansion along row 0, five stages.
// ----------------------------------------------------------------------------
module sl3_det3 (
    input  logic                     clk,
    input  logic                     en,
    input  sl3_pkg::sl3_mat_t        mat,
    output logic signed [sl3_pkg::DW-1:0] det
);
    import sl3_pkg::*;

    logic signed [63:0] p48_reg, p57_reg, p38_reg, p56_reg, p37_reg, p46_reg;
    fix_t               r1_reg [3];
    logic signed [64:0] c_reg [3];
    fix_t               r2_reg [3];
    logic signed [64:0] pl_reg [3];
    logic signed [64:0] ph_reg [3];
    logic signed [DW-1:0] t_reg [3];
    logic signed [DW-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: minor products
            p48_reg <= 64'(mat[4]) * 64'(mat[8]);
            p57_reg <= 64'(mat[5]) * 64'(mat[7]);
            p38_reg <= 64'(mat[3]) * 64'(mat[8]);
            p56_reg <= 64'(mat[5]) * 64'(mat[6]);
            p37_reg <= 64'(mat[3]) * 64'(mat[7]);
            p46_reg <= 64'(mat[4]) * 64'(mat[6]);
            for (int k = 0; k < 3; k++)
            begin
                r1_reg[k] <= mat[k];
            end
            // stage 2: cofactors
            c_reg[0] <= 65'(p48_reg) - 65'(p57_reg);
            c_reg[1] <= 65'(p38_reg) - 65'(p56_reg);
            c_reg[2] <= 65'(p37_reg) - 65'(p46_reg);
            r2_reg   <= r1_reg;
            // stage 3: row entry times cofactor halves
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[k] <= 65'(r2_reg[k]) * 65'($signed({1'b0, c_reg[k][31:0]}));
                ph_reg[k] <= 65'(r2_reg[k]) * 65'($signed(c_reg[k][64:32]));
            end
            // stage 4: recombine halves
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k] <= (DW'(ph_reg[k]) <<< 32) + DW'(pl_reg[k]);
            end
            // stage 5: alternating sum
            det_reg <= t_reg[0] - t_reg[1] + t_reg[2];
        end
    end

    assign det = det_reg;

endmodule

// ===== hw/rtl/sl3_norm.sv =====
// ----------------------------------------------------------------------------
// sl3_norm
// Sum of squares of the matrix entries times the tolerance, five stages.
// ----------------------------------------------------------------------------
module sl3_norm (
    input  logic                       clk,
    input  logic                       en,
    input  sl3_pkg::sl3_mat_t          mat,
    input  logic [sl3_pkg::TW-1:0]     tol,
    output logic [sl3_pkg::RHW-1:0]    bound
);
    import sl3_pkg::*;

    logic [62:0]     sq_reg [9];
    logic [63:0]     grp_reg [3];
    logic [SW-1:0]   s_reg;
    logic [56:0]     pll_reg, plh_reg, phl_reg, phh_reg;
    logic [RHW-1:0]  bound_reg;
    logic signed [63:0] sq_c [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            sq_c[k] = 64'(mat[k]) * 64'(mat[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                sq_reg[k] <= sq_c[k][62:0];
            end
            for (int g = 0; g < 3; g++)
            begin
                grp_reg[g] <= 64'(sq_reg[3*g]) + 64'(sq_reg[3*g+1]) + 64'(sq_reg[3*g+2]);
            end
            s_reg <= SW'(grp_reg[0]) + SW'(grp_reg[1]) + SW'(grp_reg[2]);
            // 33x24 partial products of sum times tolerance
            pll_reg <= 57'(s_reg[32:0])  * 57'(tol[23:0]);
            plh_reg <= 57'(s_reg[32:0])  * 57'(tol[47:24]);
            phl_reg <= 57'(s_reg[65:33]) * 57'(tol[23:0]);
            phh_reg <= 57'(s_reg[65:33]) * 57'(tol[47:24]);
            bound_reg <= RHW'(pll_reg) + (RHW'(plh_reg) << 24)
                       + (RHW'(phl_reg) << 33) + (RHW'(phh_reg) << 57);
        end
    end

    assign bound = bound_reg;

endmodule

// ===== hw/rtl/sl3_div_step.sv =====
// ----------------------------------------------------------------------------
// sl3_div_step
// One restoring-division stage: one quotient bit for each of three lanes.
// ----------------------------------------------------------------------------
module sl3_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  sl3_pkg::sl3_div_t   din,
    output logic                out_valid,
    output sl3_pkg::sl3_div_t   dout
);
    import sl3_pkg::*;

    logic     valid_reg;
    sl3_div_t st_reg;
    sl3_div_t st_next;
    logic [DVW:0] rem_sh;
    logic [DVW:0] dvs_x;
    logic         ge;

    always_comb
    begin
        st_next = din;
        dvs_x   = {1'b0, din.dvs};
        for (int l = 0; l < LANES; l++)
        begin
            rem_sh = {din.rem[l], din.nlow[l][QW-1]};
            ge     = (rem_sh >= dvs_x);
            st_next.rem[l]  = ge ? DVW'(rem_sh - dvs_x) : rem_sh[DVW-1:0];
            st_next.nlow[l] = {din.nlow[l][QW-2:0], 1'b0};
            st_next.q[l]    = {din.q[l][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = st_reg;

endmodule

// ===== hw/rtl/solve_linear_3x3_tolerant.sv =====
// ----------------------------------------------------------------------------
// solve_linear_3x3_tolerant
// 3x3 linear solve by Cramer's rule with a relative singularity test.
// ----------------------------------------------------------------------------
// item channel: item_valid / item_stall, a matrix and right-hand side in
// signed Q16.16; a transfer happens when item_valid is high and item_stall low.
// result channel: result_valid / result_stall carrying the solution, the
// rounded determinant and a status code.
// cfg channel: cfg_valid / cfg_ready writes the 48-bit tolerance; cfg_ready is
// always high. Write it only while the pipeline is empty.
// throughput: one item per cycle unless a stalled result holds the pipeline;
// the pipeline has 41 stages (five stages for determinants and norm, three
// for singular test and setup, 32 restoring-division stages, one output
// register).
// reset: all valid bits clear, tolerance returns to 281.
// a stalled result holds the whole pipeline in place; item_stall rises in the
// same cycle, and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module solve_linear_3x3_tolerant (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  sl3_pkg::sl3_in_t           item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output sl3_pkg::sl3_out_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sl3_pkg::TW-1:0]     cfg_data
);
    import sl3_pkg::*;

    logic           en;
    logic [TW-1:0]  tol_reg;
    logic [7:0]     pre_v_reg;

    sl3_mat_t mat_a;
    sl3_mat_t mat_n [LANES];
    logic signed [DW-1:0] d5;
    logic signed [DW-1:0] n5 [LANES];
    logic [RHW-1:0] bound5;

    // setup stage registers
    logic [UW-1:0]  ud6_reg;
    logic [UW-1:0]  un6_reg [LANES];
    logic [LANES-1:0] neg6_reg;
    logic           dzero6_reg;
    logic [RSH_W-1:0] dsh6_reg;
    logic [RHW-1:0] bound6_reg;

    logic [DVW-1:0] rem7_reg [LANES];
    logic [QW-1:0]  nlow7_reg [LANES];
    logic [LANES-1:0] neg7_reg;
    logic [DVW-1:0] dvs7_reg;
    logic           sing7_reg;
    logic           dsat7_reg;
    logic signed [63:0] det7_reg;

    sl3_div_t div8_reg;
    sl3_div_t div_st [DIV_STEPS+1];
    logic     div_v  [DIV_STEPS+1];

    logic     res_valid_reg;
    sl3_out_t res_reg;
    sl3_out_t res_next;

    logic [UW-1:0]  ud_c;
    logic [UW-1:0]  un_c [LANES];
    logic [DW:0]    rdw_c;
    logic [NW-1:0]  num_c [LANES];

    assign en         = !res_valid_reg || !result_stall;
    assign item_stall = !en;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    // matrix and the three column-substituted matrices
    always_comb
    begin
        mat_a = {item.m22, item.m21, item.m20, item.m12, item.m11, item.m10,
                 item.m02, item.m01, item.m00};
        for (int l = 0; l < LANES; l++)
        begin
            mat_n[l]      = mat_a;
            mat_n[l][l]   = item.rhs0;
            mat_n[l][3+l] = item.rhs1;
            mat_n[l][6+l] = item.rhs2;
        end
    end

    sl3_det3 u_det (
        .clk (clk),
        .en  (en),
        .mat (mat_a),
        .det (d5)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_num
        sl3_det3 u_num (
            .clk (clk),
            .en  (en),
            .mat (mat_n[g]),
            .det (n5[g])
        );
    end

    sl3_norm u_norm (
        .clk   (clk),
        .en    (en),
        .mat   (mat_a),
        .tol   (tol_reg),
        .bound (bound5)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= '0;
        end
        else if (en)
        begin
            pre_v_reg <= {pre_v_reg[6:0], item_valid};
        end
    end

    always_comb
    begin
        ud_c  = d5[DW-1] ? UW'(-d5) : UW'(d5);
        for (int l = 0; l < LANES; l++)
        begin
            un_c[l]  = n5[l][DW-1] ? UW'(-n5[l]) : UW'(n5[l]);
            num_c[l] = NW'({un6_reg[l], 17'b0}) + NW'(ud6_reg);
        end
        // round half up before dropping 32 fraction bits
        rdw_c = {d5[DW-1], d5} + {{(DW-31){1'b0}}, 1'b1, 31'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes, signs, rounding
            ud6_reg    <= ud_c;
            for (int l = 0; l < LANES; l++)
            begin
                un6_reg[l]  <= un_c[l];
                neg6_reg[l] <= n5[l][DW-1] ^ d5[DW-1];
            end
            dzero6_reg <= (d5 == '0);
            dsh6_reg   <= rdw_c[DW:32];
            bound6_reg <= bound5;

            // singular test, determinant clamp, dividend setup
            sing7_reg <= dzero6_reg || ({ud6_reg, 32'b0} < (UW+32)'(bound6_reg));
            if (dsh6_reg[RSH_W-1:63] == '0 || dsh6_reg[RSH_W-1:63] == '1)
            begin
                dsat7_reg <= 1'b0;
                det7_reg  <= $signed(dsh6_reg[63:0]);
            end
            else
            begin
                dsat7_reg <= 1'b1;
                det7_reg  <= dsh6_reg[RSH_W-1] ? 64'sh8000_0000_0000_0000
                                               : 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            for (int l = 0; l < LANES; l++)
            begin
                rem7_reg[l]  <= DVW'(num_c[l][NW-1:QW]);
                nlow7_reg[l] <= num_c[l][QW-1:0];
            end
            neg7_reg <= neg6_reg;
            dvs7_reg <= {ud6_reg, 1'b0};

            // quotient overflow check, divider entry
            for (int l = 0; l < LANES; l++)
            begin
                div8_reg.rem[l]  <= rem7_reg[l];
                div8_reg.nlow[l] <= nlow7_reg[l];
                div8_reg.q[l]    <= '0;
                div8_reg.ovf[l]  <= (rem7_reg[l] >= dvs7_reg);
            end
            div8_reg.neg      <= neg7_reg;
            div8_reg.dvs      <= dvs7_reg;
            div8_reg.singular <= sing7_reg;
            div8_reg.det_sat  <= dsat7_reg;
            div8_reg.det      <= det7_reg;
        end
    end

    assign div_st[0] = div8_reg;
    assign div_v[0]  = pre_v_reg[7];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        sl3_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_v[s]),
            .din       (div_st[s]),
            .out_valid (div_v[s+1]),
            .dout      (div_st[s+1])
        );
    end

    // clamp, sign and status
    always_comb
    begin
        logic [QW-1:0]  lim;
        logic [QW-1:0]  qv;
        logic           any_sat;
        fix_t           sol [LANES];
        any_sat = div_st[DIV_STEPS].det_sat;
        for (int l = 0; l < LANES; l++)
        begin
            lim = div_st[DIV_STEPS].neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (div_st[DIV_STEPS].ovf[l] || div_st[DIV_STEPS].q[l] > lim)
            begin
                qv      = lim;
                any_sat = 1'b1;
            end
            else
            begin
                qv = div_st[DIV_STEPS].q[l];
            end
            sol[l] = div_st[DIV_STEPS].neg[l] ? $signed(-qv) : $signed(qv);
        end
        res_next.determinant = div_st[DIV_STEPS].det;
        if (div_st[DIV_STEPS].singular)
        begin
            res_next.sol0   = '0;
            res_next.sol1   = '0;
            res_next.sol2   = '0;
            res_next.status = ST_SINGULAR;
        end
        else
        begin
            res_next.sol0   = sol[0];
            res_next.sol1   = sol[1];
            res_next.sol2   = sol[2];
            res_next.status = any_sat ? ST_SATURATED : ST_SOLVED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= div_v[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== tb/sl3_checker.sv =====
// ----------------------------------------------------------------------------
// sl3_checker
// Watches the item, result and cfg channels of the 3x3 solver, predicts each
// result from the transferred item and the current tolerance, and compares.
// ----------------------------------------------------------------------------
module sl3_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  sl3_pkg::sl3_in_t       item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  sl3_pkg::sl3_out_t      result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [sl3_pkg::TW-1:0] cfg_data,
    output int                     fails,
    output int                     pending
);
    import sl3_pkg::*;

    typedef logic signed [127:0] wide_t;

    logic [TW-1:0] tolerance;
    sl3_out_t      solutions_due[$];

    function automatic wide_t det3(input wide_t a [9]);
        return a[0] * (a[4] * a[8] - a[5] * a[7])
             - a[1] * (a[3] * a[8] - a[5] * a[6])
             + a[2] * (a[3] * a[7] - a[4] * a[6]);
    endfunction

    function automatic sl3_out_t solve_cramer(input sl3_in_t x, input logic [TW-1:0] tol);
        wide_t         a [9];
        wide_t         t [9];
        wide_t         r [3];
        wide_t         d;
        wide_t         num;
        wide_t         rd;
        logic [191:0]  sumsq;
        logic [191:0]  lhs;
        logic [191:0]  rhs;
        logic [159:0]  un;
        logic [159:0]  ud;
        logic [159:0]  q;
        logic [31:0]   lim;
        logic [31:0]   qv;
        logic          neg;
        logic          sat;
        sl3_out_t      o;
        a = '{x.m00, x.m01, x.m02, x.m10, x.m11, x.m12, x.m20, x.m21, x.m22};
        r = '{x.rhs0, x.rhs1, x.rhs2};
        sat = 1'b0;
        o = '0;
        d = det3(a);
        // round half up to Q48.16, then clamp
        rd = (d + (wide_t'(1) <<< 31)) >>> 32;
        if (rd > wide_t'(64'sh7FFF_FFFF_FFFF_FFFF)) begin
            o.determinant = 64'sh7FFF_FFFF_FFFF_FFFF;
            sat = 1'b1;
        end
        else if (rd < -(wide_t'(1) <<< 63)) begin
            o.determinant = 64'sh8000_0000_0000_0000;
            sat = 1'b1;
        end
        else
            o.determinant = rd[63:0];
        sumsq = '0;
        for (int k = 0; k < 9; k++)
            sumsq += 192'(a[k] * a[k]);
        ud = (d < 0) ? 160'(-d) : 160'(d);
        lhs = 192'(ud) << 32;
        rhs = sumsq * tol;
        if (sumsq == 0 || d == 0 || lhs < rhs) begin
            o.status = ST_SINGULAR;
            return o;
        end
        for (int i = 0; i < 3; i++) begin
            t = a;
            for (int k = 0; k < 3; k++)
                t[k * 3 + i] = r[k];
            num = det3(t);
            neg = (num < 0) != (d < 0);
            un = (num < 0) ? 160'(-num) : 160'(num);
            q = ((un << 17) + ud) / (ud << 1);
            lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (q > 160'(lim)) begin
                qv = lim;
                sat = 1'b1;
            end
            else
                qv = q[31:0];
            qv = neg ? -qv : qv;
            case (i)
                0: o.sol0 = qv;
                1: o.sol1 = qv;
                default: o.sol2 = qv;
            endcase
        end
        o.status = sat ? ST_SATURATED : ST_SOLVED;
        return o;
    endfunction

    assign pending = solutions_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        sl3_out_t want;
        if (!rst_n) begin
            tolerance <= TOL_RESET;
            fails     <= 0;
            solutions_due.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                tolerance <= cfg_data;
            if (item_valid && !item_stall)
                solutions_due.push_back(solve_cramer(item, tolerance));
            if (result_valid && !result_stall) begin
                if (solutions_due.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, result);
                    fails <= fails + 1;
                end
                else begin
                    want = solutions_due.pop_front();
                    if (result.sol0 !== want.sol0 || result.sol1 !== want.sol1 ||
                        result.sol2 !== want.sol2 ||
                        result.determinant !== want.determinant ||
                        result.status !== want.status) begin
                        $display("%0t: mismatch sol0 exp %h got %h, sol1 exp %h got %h",
                                 $realtime, want.sol0, result.sol0, want.sol1, result.sol1);
                        $display("%0t:   sol2 exp %h got %h, det exp %h got %h, st exp %0d got %0d",
                                 $realtime, want.sol2, result.sol2, want.determinant,
                                 result.determinant, want.status, result.status);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random 3x3 systems through the solver under several
// tolerance settings with random idle bursts, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import sl3_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [TW-1:0] TOL_MAX = '1;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    sl3_in_t       item;
    logic          result_valid;
    logic          result_stall;
    sl3_out_t      result;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [TW-1:0] cfg_data;
    int            fails;
    int            pending;
    logic          quiet;
    int            idle_cycles;

    solve_linear_3x3_tolerant u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    sl3_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic fix_t pick_entry(input int mode);
        case (mode)
            0: return fix_t'($urandom);
            1: return fix_t'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            2: return fix_t'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
            3: return 32'sh7FFF_FFFF;
            4: return 32'sh8000_0000;
            5: return '0;
            default: return fix_t'($signed($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    function automatic sl3_in_t random_system();
        sl3_in_t x;
        int      style;
        int      mode;
        style = $urandom_range(0, 9);
        mode = (style < 3) ? 1 : (style < 5) ? 2 : 0;
        x = {pick_entry(mode), pick_entry(mode), pick_entry(mode),
             pick_entry(mode), pick_entry(mode), pick_entry(mode),
             pick_entry(mode), pick_entry(mode), pick_entry(mode),
             pick_entry($urandom_range(0, 6)), pick_entry($urandom_range(0, 6)),
             pick_entry($urandom_range(0, 2))};
        case (style)
            // dependent or nearly dependent rows, or a lower-triangular matrix, probe the singular test
            6:
            begin
                x.m20 = x.m00 + x.m10;
                x.m21 = x.m01 + x.m11;
                x.m22 = x.m02 + x.m12;
            end
            7:
            begin
                x.m10 = x.m00;
                x.m11 = x.m01 + fix_t'($urandom_range(0, 1));
                x.m12 = x.m02;
            end
            8:
            begin
                x.m00 = pick_entry($urandom_range(0, 6));
                x.m11 = pick_entry($urandom_range(0, 6));
                x.m22 = pick_entry($urandom_range(0, 6));
                x.m01 = '0; x.m02 = '0; x.m12 = '0;
            end
            default: ;
        endcase
        return x;
    endfunction

    // one item transfer, with an occasional idle burst in front of it
    task automatic send_system(input sl3_in_t x);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic write_tolerance(input logic [TW-1:0] value);
        item_valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_system_with(input fix_t a, input fix_t b, input fix_t c,
                                    input fix_t r);
        send_system({a, b, c, b, a, b, c, b, a, r, -r, r});
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_system(random_system());
            if (n == count / 2 && !quiet)
            begin
                // let the pipeline drain completely mid-phase
                item_valid <= 1'b0;
                wait (pending == 0);
                @(posedge clk);
            end
        end
    endtask

    // result side stalls in bursts, with stretches of no stall
    initial
    begin
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL solve_linear_3x3_tolerant");
            $finish;
        end
    end

    initial
    begin
        fix_t lo;
        fix_t hi;
        lo = 32'sh8000_0000;
        hi = 32'sh7FFF_FFFF;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        quiet       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed systems at the reset tolerance
        send_system('0);
        send_system({32'sh1_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh1_0000, 32'sh0,
                     32'sh0, 32'sh0, 32'sh1_0000, 32'sh3_0000, -32'sh2_8000, 32'sh1});
        send_system({lo, 32'sh0, 32'sh0, 32'sh0, lo, 32'sh0, 32'sh0, 32'sh0, lo, hi, lo, hi});
        send_system({hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi});
        send_system({lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo});
        // largest determinant, still within the 64-bit result
        send_system({lo, lo, lo, lo, hi, lo, lo, lo, hi, lo, hi, lo});
        send_system({hi, hi, hi, hi, lo, hi, hi, hi, lo, hi, lo, hi});
        // tiny determinant with large right-hand side: solution saturates
        send_system({32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1,
                     hi, lo, 32'sh1});
        // tiny but relatively significant versus tiny entries
        send_system({32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh0, -32'sh1,
                     32'sh1, 32'sh0, -32'sh1});
        // near singular: small det against a large norm
        send_system({hi, hi, 32'sh0, hi, hi - 1, 32'sh0, 32'sh0, 32'sh0, 32'sh1,
                     32'sh1_0000, 32'sh1_0000, 32'sh1_0000});
        send_system({32'sh2_0000, 32'sh4_0000, 32'sh6_0000, 32'sh1_0000, 32'sh2_0000,
                     32'sh3_0000, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh1, 32'sh2, 32'sh3});
        send_system({32'sh0, 32'sh0, 32'sh0, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000,
                     32'sh4_0000, 32'sh5_0000, 32'sh6_0000, 32'sh1, 32'sh1, 32'sh1});
        // solutions of odd halves
        send_system({32'sh2, 32'sh0, 32'sh0, 32'sh0, 32'sh2, 32'sh0, 32'sh0, 32'sh0, 32'sh2,
                     32'sh3, -32'sh3, 32'sh1});
        send_system({-32'sh2, 32'sh0, 32'sh0, 32'sh0, 32'sh4, 32'sh0, 32'sh0, 32'sh0, -32'sh4,
                     32'sh3, -32'sh6, 32'sh2});
        send_system_with(32'sh1_0000, -32'sh1, 32'sh0, hi);
        send_system_with(hi, lo, 32'sh0, lo);
        send_system_with(32'sh10_0000, 32'sh8_0000, 32'sh0, 32'sh7_FFFF);
        send_system({32'sh0, 32'sh1_0000, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                     32'sh1_0000, lo, hi, 32'sh0});

        send_random(300);
        write_tolerance('0);
        send_system({32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1,
                     32'sh5, 32'sh5, 32'sh5});
        send_system({hi, hi, 32'sh0, hi, hi - 1, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh1,
                     32'sh1, 32'sh1});
        send_random(300);
        write_tolerance(TOL_MAX);
        send_random(200);
        write_tolerance(TW'({$urandom, $urandom}) >> $urandom_range(8, 40));
        send_random(300);
        write_tolerance(TW'({$urandom, $urandom}) >> $urandom_range(0, 47));
        send_random(250);
        write_tolerance(TOL_RESET);
        send_random(150);
        quiet = 1'b1;
        send_random(200);
        item_valid <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fails == 0)
            $display("PASS solve_linear_3x3_tolerant");
        else
            $display("FAIL solve_linear_3x3_tolerant");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sl3_pkg.sv
hw/rtl/sl3_det3.sv
hw/rtl/sl3_norm.sv
hw/rtl/sl3_div_step.sv
hw/rtl/solve_linear_3x3_tolerant.sv
tb/sl3_checker.sv
tb/tb_top.sv
